// File: rtl/eq_pkg.sv
// ----------------------------------------------------------------------------
// eq_pkg
// Shared types, constants and the arctangent table for the Euler to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package eq_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int STEPS      = 30;
  localparam int INT_FRAC   = 30;
  localparam int CW         = 34;
  localparam int PW         = 2 * CW;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } req_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } res_t;

  typedef struct packed {
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] cp;
    logic signed [CW-1:0] sp;
    logic signed [CW-1:0] cr;
    logic signed [CW-1:0] sr;
  } sincos_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic signed [CW-1:0] atan_f(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return CW'(v);
  endfunction

endpackage

// File: rtl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Yaw/pitch/roll binary angles to a Z-Y-X unit quaternion in Q1.14.
//
//   channel   dir  handshake            payload
//   in        in   in_valid_i/in_stall_o  eq_pkg::req_t (yaw, pitch, roll)
//   out       out  out_valid_o/out_stall_i eq_pkg::res_t (w, x, y, z)
//
// One request per cycle sustained while nothing stalls; the path runs through
// 31 CORDIC stages, the queue, two multiplier stages and an output register.
// Reset clears all valid bits and queue pointers; no state links requests.
// An output stall holds the product pipeline; the CORDIC keeps running until
// the four-entry queue fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  eq_pkg::req_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output eq_pkg::res_t  out_res_o
);
  import eq_pkg::*;

  fifo_stat_t fstat;
  logic       push, pop;
  sincos_t    push_data, pop_data;

  eq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .fifo_stat_i(fstat), .push_o(push), .push_data_o(push_data)
  );

  eq_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data),
    .pop_i(pop), .pop_data_o(pop_data), .stat_o(fstat)
  );

  eq_back u_back (
    .clk_i, .rst_ni, .fifo_stat_i(fstat), .pop_data_i(pop_data),
    .pop_o(pop), .out_valid_o, .out_stall_i, .out_res_o
  );

endmodule

// File: rtl/eq_front.sv
// ----------------------------------------------------------------------------
// eq_front
// Accepts requests, halves the angles and runs three CORDIC lanes, one
// rotation step per stage, into the queue.
// ----------------------------------------------------------------------------
module eq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  eq_pkg::req_t         in_req_i,
  input  eq_pkg::fifo_stat_t   fifo_stat_i,
  output logic                 push_o,
  output eq_pkg::sincos_t      push_data_o
);
  import eq_pkg::*;

  logic                 v_q [STEPS+1];
  logic signed [CW-1:0] x_q [STEPS+1][3];
  logic signed [CW-1:0] y_q [STEPS+1][3];
  logic signed [CW-1:0] z_q [STEPS+1][3];
  logic                 en;
  logic signed [CW-1:0] z0 [3];
  logic [15:0]          raw [3];

  assign en         = !(v_q[STEPS] && fifo_stat_i.full);
  assign in_stall_o = !en;
  assign push_o     = v_q[STEPS] && en;

  assign raw[0] = in_req_i.yaw_angle;
  assign raw[1] = in_req_i.pitch_angle;
  assign raw[2] = in_req_i.roll_angle;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      z0[l] = $signed({{(CW-32){raw[l][ANGLE_BITS-1]}}, raw[l][ANGLE_BITS-1:0],
                       {(32-ANGLE_BITS){1'b0}}}) >>> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= STEPS; s++) v_q[s] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int s = 1; s <= STEPS; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        x_q[0][l] <= CORDIC_GAIN;
        y_q[0][l] <= '0;
        z_q[0][l] <= z0[l];
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (!z_q[i][l][CW-1]) begin
            x_q[i+1][l] <= x_q[i][l] - (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] + (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] - atan_f(i);
          end else begin
            x_q[i+1][l] <= x_q[i][l] + (y_q[i][l] >>> i);
            y_q[i+1][l] <= y_q[i][l] - (x_q[i][l] >>> i);
            z_q[i+1][l] <= z_q[i][l] + atan_f(i);
          end
        end
      end
    end
  end

  assign push_data_o.cy = x_q[STEPS][0];
  assign push_data_o.sy = y_q[STEPS][0];
  assign push_data_o.cp = x_q[STEPS][1];
  assign push_data_o.sp = y_q[STEPS][1];
  assign push_data_o.cr = x_q[STEPS][2];
  assign push_data_o.sr = y_q[STEPS][2];

endmodule

// File: rtl/eq_fifo.sv
// ----------------------------------------------------------------------------
// eq_fifo
// Short queue of sine/cosine sets between the CORDIC and product pipelines.
// ----------------------------------------------------------------------------
module eq_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  eq_pkg::sincos_t     push_data_i,
  input  logic                pop_i,
  output eq_pkg::sincos_t     pop_data_o,
  output eq_pkg::fifo_stat_t  stat_o
);
  import eq_pkg::*;

  sincos_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full)) else $error("queue overflow");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty)) else $error("queue underflow");
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

// File: rtl/eq_back.sv
// ----------------------------------------------------------------------------
// eq_back
// Forms the triple products, sums them and rounds/saturates to Q1.14.
// ----------------------------------------------------------------------------
module eq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  eq_pkg::fifo_stat_t  fifo_stat_i,
  input  eq_pkg::sincos_t     pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output eq_pkg::res_t        out_res_o
);
  import eq_pkg::*;

  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (INT_FRAC - 1);
  localparam int SH = INT_FRAC - FRAC_BITS;
  localparam logic signed [CW+1:0] OHALF = (CW+2)'(1) <<< (SH - 1);
  localparam logic signed [CW+1:0] LIM = (CW+2)'(1) <<< FRAC_BITS;

  logic adv;
  logic va_q, vb_q, vc_q;
  // stage A: pair products
  logic signed [PW-1:0] cycp_q, sysp_q, sycp_q, cysp_q;
  logic signed [CW-1:0] cr_q, sr_q;
  // stage B: triple products
  logic signed [PW-1:0] t_q [8];
  logic signed [CW-1:0] pr [4];
  logic signed [CW-1:0] tr [8];
  logic signed [CW+1:0] sm [4];
  logic [15:0]          qo [4];
  res_t                 res_q;

  function automatic logic signed [CW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + HALF) >>> INT_FRAC;
    return t[CW-1:0];
  endfunction

  function automatic logic [15:0] sat(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] t;
    t = (v + OHALF) >>> SH;
    if (t > LIM) t = LIM;
    if (t < -LIM) t = -LIM;
    return t[15:0];
  endfunction

  assign adv         = !(vc_q && out_stall_i);
  assign pop_o       = adv && !fifo_stat_i.empty;
  assign out_valid_o = vc_q;
  assign out_res_o   = res_q;

  always_comb begin
    pr[0] = rnd(cycp_q);
    pr[1] = rnd(sysp_q);
    pr[2] = rnd(sycp_q);
    pr[3] = rnd(cysp_q);
    for (int k = 0; k < 8; k++) tr[k] = rnd(t_q[k]);
    sm[0] = (CW+2)'(tr[0]) + (CW+2)'(tr[1]);
    sm[1] = (CW+2)'(tr[2]) - (CW+2)'(tr[3]);
    sm[2] = (CW+2)'(tr[4]) + (CW+2)'(tr[5]);
    sm[3] = (CW+2)'(tr[6]) - (CW+2)'(tr[7]);
    for (int k = 0; k < 4; k++) qo[k] = sat(sm[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv) begin
      va_q <= !fifo_stat_i.empty;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cycp_q <= PW'(pop_data_i.cy) * PW'(pop_data_i.cp);
      sysp_q <= PW'(pop_data_i.sy) * PW'(pop_data_i.sp);
      sycp_q <= PW'(pop_data_i.sy) * PW'(pop_data_i.cp);
      cysp_q <= PW'(pop_data_i.cy) * PW'(pop_data_i.sp);
      cr_q   <= pop_data_i.cr;
      sr_q   <= pop_data_i.sr;
      t_q[0] <= PW'(pr[0]) * PW'(cr_q);
      t_q[1] <= PW'(pr[1]) * PW'(sr_q);
      t_q[2] <= PW'(pr[0]) * PW'(sr_q);
      t_q[3] <= PW'(pr[1]) * PW'(cr_q);
      t_q[4] <= PW'(pr[2]) * PW'(sr_q);
      t_q[5] <= PW'(pr[3]) * PW'(cr_q);
      t_q[6] <= PW'(pr[2]) * PW'(cr_q);
      t_q[7] <= PW'(pr[3]) * PW'(sr_q);
      res_q.quat_w <= qo[0];
      res_q.quat_x <= qo[1];
      res_q.quat_y <= qo[2];
      res_q.quat_z <= qo[3];
    end
  end

endmodule
